/* rtl/core/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define CHK_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("port check failed");

// next-cycle implication, quiet during reset
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

/* rtl/core/vrbc_pkg.sv */
// ----------------------------------------------------------------------------
// vrbc_pkg
// Shared types and constants of the ray box clipper.
// ----------------------------------------------------------------------------
package vrbc_pkg;

  localparam int MaxRays   = 16;
  localparam int MaxBv     = 36;
  localparam int ResultCap = 43;

  localparam int RcW  = $clog2(MaxRays + 1);
  localparam int ScW  = $clog2(MaxBv + 1);
  localparam int IdxW = $clog2(MaxBv);
  localparam int NcW  = $clog2(ResultCap + 1);

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_LEFT   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BOTTOM = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RIGHT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TOP    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BASE   = 3'd4;

  localparam logic KIND_VERTEX  = 1'b0;
  localparam logic KIND_SEGMENT = 1'b1;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // what the back part has to do for a queued item
  typedef enum logic [1:0] {
    RK_NONE,
    RK_FIRST,
    RK_SECOND,
    RK_LINE
  } ray_kind_t;

  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] bottom;
    logic signed [31:0] right;
    logic signed [31:0] top;
    logic [15:0]        base;
  } cfg_t;

  typedef struct packed {
    ray_kind_t          kind;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic [15:0]        e1;
    logic [15:0]        e2;
    logic               fin;
    logic               ovf;
  } entry_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        s;
    logic [15:0]        e;
    logic               ovf;
  } result_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL,
    B_SUB,
    B_DSTART,
    B_DWAIT,
    B_PICK,
    B_EMIT,
    B_CSCAN,
    B_CORNER,
    B_ESCAN,
    B_ESTEP,
    B_FLUSH
  } back_state_t;

endpackage

/* rtl/core/vrbc_fifo.sv */
// ----------------------------------------------------------------------------
// vrbc_fifo
// Two-word queue between the front and the back part.
// ----------------------------------------------------------------------------
module vrbc_fifo import vrbc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output entry_t pop_data,
  output logic   empty
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/core/vrbc_div.sv */
// ----------------------------------------------------------------------------
// vrbc_div
// Signed 64 by 32 divider, one quotient bit a cycle, saturating to 32 bits.
// ----------------------------------------------------------------------------
module vrbc_div import vrbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] q
);

  localparam logic [4:0] DivSteps = 5'd31;

  logic        num_neg;
  logic [63:0] neg_num;
  logic [62:0] mag_n;
  logic [31:0] neg_den;
  logic [31:0] mag_d;
  logic        sat;

  logic [31:0] rem;
  logic [30:0] sh;
  logic [31:0] dreg;
  logic        neg;
  logic [4:0]  cnt;
  logic        busy;

  logic [33:0] trial;
  logic        ge;
  logic [31:0] rem_next;
  logic [30:0] sh_next;

  // magnitudes and early saturation
  always_comb begin
    num_neg = num[63];
    neg_num = -num;
    mag_n   = num_neg ? neg_num[62:0] : num[62:0];
    neg_den = -den;
    mag_d   = den[31] ? neg_den : den;
    sat     = (mag_n[62:31] >= mag_d);
  end

  // one restoring step
  always_comb begin
    trial    = {1'b0, rem, sh[30]} - {2'b00, dreg};
    ge       = ~trial[33];
    rem_next = ge ? trial[31:0] : {rem[30:0], sh[30]};
    sh_next  = {sh[29:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        if (den == 32'sd0) begin
          q    <= num_neg ? Q_MIN : ((num != 64'sd0) ? Q_MAX : 32'sd0);
          done <= 1'b1;
        end else if (sat) begin
          q    <= (num_neg ^ den[31]) ? Q_MIN : Q_MAX;
          done <= 1'b1;
        end else begin
          rem  <= mag_n[62:31];
          sh   <= mag_n[30:0];
          dreg <= mag_d;
          neg  <= num_neg ^ den[31];
          cnt  <= DivSteps;
          busy <= 1'b1;
          done <= 1'b0;
        end
      end else if (busy) begin
        rem <= rem_next;
        sh  <= sh_next;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
          q    <= neg ? -$signed({1'b0, sh_next}) : $signed({1'b0, sh_next});
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/vrbc_front.sv */
// ----------------------------------------------------------------------------
// vrbc_front
// Takes segment words and configuration writes, sorts out rays, keeps the
// admission counters and the sticky overflow flag.
// ----------------------------------------------------------------------------
module vrbc_front import vrbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   line_a,
  input  logic signed [31:0]   line_b,
  input  logic signed [31:0]   line_c,
  input  logic [15:0]          first_end,
  input  logic                 first_known,
  input  logic [15:0]          second_end,
  input  logic                 second_known,
  input  logic                 final_segment,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [31:0]          cfg_data,
  output cfg_t                 cfg,
  output logic                 push,
  output entry_t               push_entry,
  input  logic                 q_full
);

  logic [RcW-1:0] rc;
  logic [ScW-1:0] sc;
  logic           ovf;

  logic           accept;
  logic           is_ray;
  logic           is_line;
  logic [ScW:0]   need;
  logic [ScW:0]   room;
  logic           drop;
  logic           admit;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !q_full;

  // classify the word
  always_comb begin
    is_ray  = !(first_known && second_known);
    is_line = !first_known && !second_known;
    need    = is_line ? (ScW+1)'(2) : (ScW+1)'(1);
    room    = {1'b0, sc} + need + (ScW+1)'(4);
    drop    = is_ray && ((rc >= RcW'(MaxRays)) || (room > (ScW+1)'(MaxBv)));
    admit   = is_ray && !drop;
    push    = accept && (admit || final_segment);

    push_entry.kind = RK_NONE;
    if (admit) begin
      if (is_line)          push_entry.kind = RK_LINE;
      else if (first_known) push_entry.kind = RK_FIRST;
      else                  push_entry.kind = RK_SECOND;
    end
    push_entry.a   = line_a;
    push_entry.b   = line_b;
    push_entry.c   = line_c;
    push_entry.e1  = first_end;
    push_entry.e2  = second_end;
    push_entry.fin = final_segment;
    push_entry.ovf = ovf || drop;
  end

  // admission counters
  always_ff @(posedge clk) begin
    if (rst) begin
      rc  <= '0;
      sc  <= '0;
      ovf <= 1'b0;
    end else if (accept) begin
      if (final_segment) begin
        rc  <= '0;
        sc  <= '0;
        ovf <= 1'b0;
      end else begin
        if (admit) begin
          rc <= rc + RcW'(1);
          sc <= sc + need[ScW-1:0];
        end
        if (drop) ovf <= 1'b1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left   <= 32'sd0;
      cfg.bottom <= 32'sd0;
      cfg.right  <= 32'sd65536;
      cfg.top    <= 32'sd65536;
      cfg.base   <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEFT:   cfg.left   <= cfg_data;
        CFG_BOTTOM: cfg.bottom <= cfg_data;
        CFG_RIGHT:  cfg.right  <= cfg_data;
        CFG_TOP:    cfg.top    <= cfg_data;
        CFG_BASE:   cfg.base   <= cfg_data[15:0];
        default:    ;
      endcase
    end
  end

endmodule

/* rtl/core/vrbc_back.sv */
// ----------------------------------------------------------------------------
// vrbc_back
// Works off queued words: intercepts through a shared multiplier and divider,
// vertex store, corner insertion, perimeter ordering and the result register.
// ----------------------------------------------------------------------------
module vrbc_back import vrbc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_empty,
  input  entry_t  q_data,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res,
  output logic    out_last
);

  back_state_t state, state_next;

  entry_t             cur;
  logic [1:0]         dsel;
  logic signed [63:0] prod;
  logic signed [63:0] num;
  logic signed [31:0] res [4];
  logic signed [31:0] lx, ly, rx, ry;
  logic [15:0]        first_idx;
  logic [1:0]         step;
  logic [ScW-1:0]     cnt;

  // vertex store
  logic [31:0]        mem_x [MaxBv];
  logic [31:0]        mem_y [MaxBv];
  logic               wr_en;
  logic signed [31:0] wr_x, wr_y;

  // scan pipeline
  logic [ScW-1:0]     rd_ptr;
  logic               rd_vld;
  logic [IdxW-1:0]    rd_idx;
  logic signed [31:0] rd_x, rd_y;
  logic               issue;
  logic               scan_done;
  logic               scan_init;

  // corners
  logic [3:0]         cm;
  logic [3:0]         added;
  logic [1:0]         ck;
  logic signed [31:0] cxs [4];
  logic signed [31:0] cys [4];
  logic               dup;
  logic               need_add;

  // perimeter
  logic [1:0]         eside;
  logic               best_found, prev_found;
  logic signed [31:0] best_key, prev_key;
  logic [IdxW-1:0]    best_idx, prev_idx;
  logic               e_match;
  logic signed [31:0] e_key;
  logic               e_take;

  // results
  logic               pend_valid;
  result_t            pend;
  logic [NcW-1:0]     nres;
  logic               out_free;
  logic               can_produce;
  logic               gen;
  result_t            gen_res;
  logic               flush_push;
  logic               go;
  logic               take;

  // shared multiplier and divider
  logic signed [31:0] mul_a, mul_b, div_den;
  logic signed [63:0] c2;
  logic               div_start, div_done;
  logic signed [31:0] div_q;

  vrbc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  // operand selection for the four intercepts
  always_comb begin
    mul_a   = dsel[1] ? cur.b : cur.a;
    div_den = dsel[1] ? cur.a : cur.b;
    case (dsel)
      2'd0:    mul_b = cfg.left;
      2'd1:    mul_b = cfg.right;
      2'd2:    mul_b = cfg.bottom;
      default: mul_b = cfg.top;
    endcase
    c2 = {{16{cur.c[31]}}, cur.c, 16'd0};
  end

  // corners in insertion order
  always_comb begin
    cxs[0] = cfg.left;  cys[0] = cfg.bottom;
    cxs[1] = cfg.right; cys[1] = cfg.bottom;
    cxs[2] = cfg.right; cys[2] = cfg.top;
    cxs[3] = cfg.left;  cys[3] = cfg.top;
    dup = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if ((2'(j) < ck) && added[j] && (cxs[j] == cxs[ck]) && (cys[j] == cys[ck])) begin
        dup = 1'b1;
      end
    end
    need_add = !cm[ck] && !dup;
  end

  // edge membership and ordering of the entry under scan
  always_comb begin
    case (eside)
      2'd0:    begin e_match = (rd_y == cfg.top);    e_key = rd_x; end
      2'd1:    begin e_match = (rd_y == cfg.bottom); e_key = rd_x; end
      2'd2:    begin e_match = (rd_x == cfg.left);   e_key = rd_y; end
      default: begin e_match = (rd_x == cfg.right);  e_key = rd_y; end
    endcase
    e_take = e_match
          && (!prev_found || (e_key > prev_key) || ((e_key == prev_key) && (rd_idx > prev_idx)))
          && (!best_found || (e_key < best_key));
  end

  assign issue       = (rd_ptr != cnt);
  assign scan_done   = !issue && !rd_vld;
  assign out_free    = !out_valid || !out_stall;
  assign can_produce = !pend_valid || out_free;
  assign take        = gen && can_produce && (nres < NcW'(ResultCap));

  // next state and strobes
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    div_start  = 1'b0;
    gen        = 1'b0;
    gen_res    = '0;
    gen_res.ovf = cur.ovf;
    wr_en      = 1'b0;
    wr_x       = lx;
    wr_y       = ly;
    scan_init  = 1'b0;
    flush_push = 1'b0;
    go         = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          scan_init  = 1'b1;
          state_next = (q_data.kind != RK_NONE) ? B_MUL : B_CSCAN;
        end
      end
      B_MUL:    state_next = B_SUB;
      B_SUB:    state_next = B_DSTART;
      B_DSTART: begin
        div_start  = 1'b1;
        state_next = B_DWAIT;
      end
      B_DWAIT: begin
        if (div_done) state_next = (dsel == 2'd3) ? B_PICK : B_MUL;
      end
      B_PICK: state_next = B_EMIT;
      B_EMIT: begin
        gen = 1'b1;
        if ((cur.kind == RK_LINE) ? (step < 2'd2) : (step == 2'd0)) begin
          gen_res.kind = KIND_VERTEX;
          if ((cur.kind == RK_SECOND) || ((cur.kind == RK_LINE) && (step == 2'd0))) begin
            gen_res.x = lx; gen_res.y = ly;
          end else begin
            gen_res.x = rx; gen_res.y = ry;
          end
          wr_en = can_produce;
          wr_x  = gen_res.x;
          wr_y  = gen_res.y;
        end else begin
          gen_res.kind = KIND_SEGMENT;
          case (cur.kind)
            RK_LINE:  begin gen_res.s = first_idx; gen_res.e = first_idx + 16'd1; end
            RK_FIRST: begin gen_res.s = cur.e1;    gen_res.e = first_idx;         end
            default:  begin gen_res.s = cur.e2;    gen_res.e = first_idx;         end
          endcase
        end
        if (can_produce && ((cur.kind == RK_LINE) ? (step == 2'd2) : (step == 2'd1))) begin
          scan_init  = 1'b1;
          state_next = cur.fin ? B_CSCAN : B_FLUSH;
        end
      end
      B_CSCAN: begin
        if (scan_done) state_next = B_CORNER;
      end
      B_CORNER: begin
        gen          = need_add;
        gen_res.kind = KIND_VERTEX;
        gen_res.x    = cxs[ck];
        gen_res.y    = cys[ck];
        wr_x         = cxs[ck];
        wr_y         = cys[ck];
        go           = !need_add || can_produce;
        wr_en        = need_add && can_produce;
        if (go && (ck == 2'd3)) begin
          scan_init  = 1'b1;
          state_next = B_ESCAN;
        end
      end
      B_ESCAN: begin
        if (scan_done) state_next = B_ESTEP;
      end
      B_ESTEP: begin
        if (best_found) begin
          gen          = prev_found;
          gen_res.kind = KIND_SEGMENT;
          gen_res.s    = cfg.base + 16'(prev_idx);
          gen_res.e    = cfg.base + 16'(best_idx);
          go           = !prev_found || can_produce;
          if (go) begin
            scan_init  = 1'b1;
            state_next = B_ESCAN;
          end
        end else if (eside == 2'd3) begin
          state_next = B_FLUSH;
        end else begin
          scan_init  = 1'b1;
          state_next = B_ESCAN;
        end
      end
      B_FLUSH: begin
        if (!pend_valid) begin
          state_next = B_IDLE;
        end else if (out_free) begin
          flush_push = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[cnt[IdxW-1:0]] <= wr_x;
      mem_y[cnt[IdxW-1:0]] <= wr_y;
    end
    if (issue) begin
      rd_x <= mem_x[rd_ptr[IdxW-1:0]];
      rd_y <= mem_y[rd_ptr[IdxW-1:0]];
    end
  end

  // intercept datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        cur  <= q_data;
        dsel <= 2'd0;
      end
      B_MUL: prod <= mul_a * mul_b;
      B_SUB: num  <= c2 - prod;
      B_DWAIT: begin
        if (div_done) begin
          res[dsel] <= div_q;
          dsel      <= dsel + 2'd1;
        end
      end
      B_PICK: begin
        if ((res[0] >= cfg.bottom) && (res[0] <= cfg.top)) begin
          lx <= cfg.left; ly <= res[0];
        end else if (res[2] < res[3]) begin
          lx <= res[2];   ly <= cfg.bottom;
        end else begin
          lx <= res[3];   ly <= cfg.top;
        end
        if ((res[1] >= cfg.bottom) && (res[1] <= cfg.top)) begin
          rx <= cfg.right; ry <= res[1];
        end else if (res[3] > res[2]) begin
          rx <= res[3];    ry <= cfg.top;
        end else begin
          rx <= res[2];    ry <= cfg.bottom;
        end
        first_idx <= cfg.base + 16'(cnt);
        step      <= 2'd0;
      end
      B_EMIT: begin
        if (can_produce) step <= step + 2'd1;
      end
      default: ;
    endcase
  end

  // scans, corner flags and perimeter order
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr     <= '0;
      rd_vld     <= 1'b0;
      best_found <= 1'b0;
      prev_found <= 1'b0;
    end else begin
      if (scan_init) begin
        rd_ptr     <= '0;
        rd_vld     <= 1'b0;
        best_found <= 1'b0;
      end else if (state == B_CSCAN || state == B_ESCAN) begin
        rd_vld <= issue;
        rd_idx <= rd_ptr[IdxW-1:0];
        if (issue) rd_ptr <= rd_ptr + ScW'(1);
      end
      case (state)
        B_IDLE: cm <= 4'd0;
        B_CSCAN: begin
          if (rd_vld) begin
            for (int k = 0; k < 4; k++) begin
              if ((rd_x == cxs[k]) && (rd_y == cys[k])) cm[k] <= 1'b1;
            end
          end
          if (scan_done) begin
            ck    <= 2'd0;
            added <= 4'd0;
          end
        end
        B_CORNER: begin
          if (go) begin
            added[ck] <= need_add;
            ck        <= ck + 2'd1;
            if (ck == 2'd3) begin
              eside      <= 2'd0;
              prev_found <= 1'b0;
            end
          end
        end
        B_ESCAN: begin
          if (rd_vld && e_take) begin
            best_found <= 1'b1;
            best_key   <= e_key;
            best_idx   <= rd_idx;
          end
        end
        B_ESTEP: begin
          if (best_found) begin
            if (go) begin
              prev_found <= 1'b1;
              prev_key   <= best_key;
              prev_idx   <= best_idx;
            end
          end else begin
            eside      <= eside + 2'd1;
            prev_found <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // vertex count of the store
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (wr_en) begin
      cnt <= cnt + ScW'(1);
    end else if (state == B_FLUSH && state_next == B_IDLE && cur.fin) begin
      cnt <= '0;
    end
  end

  // pending word and output register; the pending word learns its last flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      nres       <= '0;
    end else begin
      if (pop) nres <= '0;
      if (take) begin
        pend       <= gen_res;
        pend_valid <= 1'b1;
        nres       <= nres + NcW'(1);
      end
      if (flush_push) pend_valid <= 1'b0;
      // output register
      if (take && pend_valid) begin
        out_res   <= pend;
        out_last  <= 1'b0;
        out_valid <= 1'b1;
      end else if (flush_push) begin
        out_res   <= pend;
        out_last  <= 1'b1;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/voronoi_ray_box_clipper_top.sv */
// ----------------------------------------------------------------------------
// voronoi_ray_box_clipper_top
// Clips open Voronoi edges to a box and closes the box perimeter.
// ----------------------------------------------------------------------------
// Input words (in_valid/in_stall) carry one segment line a*x+b*y=c with its
// two end indices. Output words (out_valid/out_stall) carry boundary vertices
// and segments, with last on the final word caused by an input word.
// Configuration writes (cfg_valid/cfg_ready, always ready) set the box and
// the vertex index base; write them only while the block is idle.
// A non-final segment with both ends known gives no word. A ray costs four
// intercepts, each one multiply plus a 31-step divider pass. The closing
// word adds a corner scan over the n stored vertices and, per box side
// holding m vertices, m+1 ordering scans, all through the single read port
// of the vertex store.
// A two-word queue lets the front take further words while the back works.
// Reset clears the counters, the overflow flag and all handshake state; the
// vertex store needs no clearing. A stalled output holds its word while work
// continues until the pending word behind it is also full.
// ----------------------------------------------------------------------------
module voronoi_ray_box_clipper_top import vrbc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  line_a,
  input  logic signed [31:0]  line_b,
  input  logic signed [31:0]  line_c,
  input  logic [15:0]         first_end,
  input  logic                first_known,
  input  logic [15:0]         second_end,
  input  logic                second_known,
  input  logic                final_segment,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                item_kind,
  output logic signed [31:0]  vertex_x,
  output logic signed [31:0]  vertex_y,
  output logic [15:0]         seg_start,
  output logic [15:0]         seg_end,
  output logic                overflow,
  output logic                last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [31:0]         cfg_data
);

  cfg_t    cfg;
  logic    push, q_full, q_empty, pop;
  entry_t  push_entry, q_data;
  result_t out_res;

  vrbc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .line_a        (line_a),
    .line_b        (line_b),
    .line_c        (line_c),
    .first_end     (first_end),
    .first_known   (first_known),
    .second_end    (second_end),
    .second_known  (second_known),
    .final_segment (final_segment),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cfg           (cfg),
    .push          (push),
    .push_entry    (push_entry),
    .q_full        (q_full)
  );

  vrbc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  vrbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .out_last  (last)
  );

  // result word fields
  assign item_kind = out_res.kind;
  assign vertex_x  = out_res.x;
  assign vertex_y  = out_res.y;
  assign seg_start = out_res.s;
  assign seg_end   = out_res.e;
  assign overflow  = out_res.ovf;

endmodule

/* rtl/core/vrbc_checker.sv */
// ----------------------------------------------------------------------------
// vrbc_checker
// Port-level checks on the result channel of the clipper.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vrbc_checker import vrbc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic               item_kind,
  input logic signed [31:0] vertex_x,
  input logic signed [31:0] vertex_y,
  input logic [15:0]        seg_start,
  input logic [15:0]        seg_end
);

  // a stalled word stays and holds
  `CHK_NEXT(a_hold_valid, out_valid && out_stall, out_valid)
  `CHK_NEXT(a_hold_word, out_valid && out_stall, $stable(vertex_x) && $stable(seg_start) && $stable(item_kind))

  // unused fields of each word kind read as zero
  `CHK_IMPLIES(a_vertex_clean, out_valid && item_kind == KIND_VERTEX, seg_start == 16'd0 && seg_end == 16'd0)
  `CHK_IMPLIES(a_segment_clean, out_valid && item_kind == KIND_SEGMENT, vertex_x == 32'sd0 && vertex_y == 32'sd0)

endmodule

bind voronoi_ray_box_clipper_top vrbc_checker u_chk (.*);
